### hw/rtl/a2mv_pkg.sv
`timescale 1ns / 1ps

package a2mv_pkg;

    // default sizes
    localparam int AMPLITUDE_BITS_DEF    = 10;
    localparam int LOG_FRACTION_BITS_DEF = 8;

    // velocity scale register and output word
    localparam int VPD_BITS     = 16;
    localparam int VELOCITY_BITS = 7;
    localparam int REGION_BITS  = 2;
    localparam int VELOCITY_MAX = 127;

    // 20*log10(2) in q16
    localparam int DB_BITS = 19;
    localparam logic [DB_BITS-1:0] DB_PER_OCTAVE_Q16 = 19'd394566;

    // normalized mantissa, q1.30
    localparam int MANT_BITS = 31;
    localparam int MANT_FRAC = 30;
    localparam int SHIFT_BITS = 5;

    // reset values of the registers
    localparam int UPPER_RESET = 1023;
    localparam int VPD_RESET   = 256;

    // configuration register indexes
    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FLOOR = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LOWER = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_UPPER = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_VPD   = 2'd3;

    // region codes of a result
    localparam logic [REGION_BITS-1:0] REGION_BELOW   = 2'd0;
    localparam logic [REGION_BITS-1:0] REGION_BETWEEN = 2'd1;
    localparam logic [REGION_BITS-1:0] REGION_ABOVE   = 2'd2;
    localparam logic [REGION_BITS-1:0] REGION_CLIPPED = 2'd3;

endpackage

### hw/rtl/amplitude_to_midi_velocity_unit.sv
`timescale 1ns / 1ps

// pipeline: a word passes stage a, stage b, the fraction stages, d, m1, m2 and the output stage
// throughput: one word per clock while the output is not stalled; each fraction
// bit of the log is one pipeline stage holding a pair of 31x31 squaring multipliers
// stalls back up stage by stage, so empty stages still fill while the output waits
// reset (rst_n low, asynchronous) empties the pipeline and loads the register
// defaults: floor 0, lower 0, upper 1023, velocity_per_db 256
module amplitude_to_midi_velocity_unit #(
    parameter int AMPLITUDE_BITS    = a2mv_pkg::AMPLITUDE_BITS_DEF,
    parameter int LOG_FRACTION_BITS = a2mv_pkg::LOG_FRACTION_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,

    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [a2mv_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [((AMPLITUDE_BITS > a2mv_pkg::VPD_BITS) ?
                   AMPLITUDE_BITS : a2mv_pkg::VPD_BITS)-1:0] cfg_wdata,

    // input words
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // amplitude, zero padded to whole bytes
    input  logic [((AMPLITUDE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,

    // result words
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    // velocity [6:0], zero [7]
    output logic [7:0] m_axis_tdata,
    // region [1:0]
    output logic [1:0] m_axis_tuser
);

    localparam int AB   = AMPLITUDE_BITS;
    localparam int LFB  = LOG_FRACTION_BITS;
    localparam int EW   = $clog2(AB);
    localparam int LW   = EW + LFB;
    localparam int MB   = a2mv_pkg::MANT_BITS;
    localparam int SQW  = 2 * MB;
    localparam int P1W  = LW + a2mv_pkg::DB_BITS;
    localparam int P2W  = P1W + a2mv_pkg::VPD_BITS;
    localparam int SH   = LFB + 24;
    localparam int HW   = P2W - SH;
    localparam int VB   = a2mv_pkg::VELOCITY_BITS;
    localparam int RB   = a2mv_pkg::REGION_BITS;

    // stage numbering
    localparam int ST_A  = 0;
    localparam int ST_B  = 1;
    localparam int ST_D  = LFB + 2;
    localparam int ST_M1 = LFB + 3;
    localparam int ST_M2 = LFB + 4;
    localparam int ST_O  = LFB + 5;
    localparam int NS    = LFB + 6;

    // leading one index
    function automatic logic [EW-1:0] lead_one(input logic [AB-1:0] x);
        logic [EW-1:0] e;
        e = '0;
        for (int i = 0; i < AB; i++)
        begin
            if (x[i])
            begin
                e = EW'(i);
            end
        end
        return e;
    endfunction

    // mantissa in q1.30 with the leading one at bit 30
    function automatic logic [MB-1:0] normalize(input logic [AB-1:0] x,
                                                input logic [EW-1:0] e);
        logic [a2mv_pkg::SHIFT_BITS-1:0] shamt;
        shamt = a2mv_pkg::SHIFT_BITS'(a2mv_pkg::MANT_FRAC) - a2mv_pkg::SHIFT_BITS'(e);
        return {{(MB - AB){1'b0}}, x} << shamt;
    endfunction

    // configuration registers
    logic [AB-1:0]                   floor_reg;
    logic [AB-1:0]                   lower_reg;
    logic [AB-1:0]                   upper_reg;
    logic [a2mv_pkg::VPD_BITS-1:0]   vpd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= '0;
            lower_reg <= '0;
            upper_reg <= AB'(a2mv_pkg::UPPER_RESET);
            vpd_reg   <= a2mv_pkg::VPD_BITS'(a2mv_pkg::VPD_RESET);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                a2mv_pkg::CFG_FLOOR: floor_reg <= cfg_wdata[AB-1:0];
                a2mv_pkg::CFG_LOWER: lower_reg <= cfg_wdata[AB-1:0];
                a2mv_pkg::CFG_UPPER: upper_reg <= cfg_wdata[AB-1:0];
                a2mv_pkg::CFG_VPD:   vpd_reg   <= cfg_wdata[a2mv_pkg::VPD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // valid bits and stall chain
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;
    logic [NS-1:0] vin;

    assign en[NS-1] = ~vld_reg[NS-1] | m_axis_tready;
    assign vin[0]   = s_axis_tvalid;

    for (genvar i = 0; i < NS - 1; i++)
    begin : g_chain
        assign en[i]     = ~vld_reg[i] | en[i+1];
        assign vin[i+1]  = vld_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vin[i];
                end
            end
        end
    end

    assign s_axis_tready = en[ST_A];

    // stage a: classify and take the differences
    logic [AB-1:0] amp;
    logic [RB-1:0] a_rgn_next;
    logic          a_calc_next;
    logic [RB-1:0] a_rgn_reg;
    logic          a_calc_reg;
    logic [AB-1:0] d1_reg;
    logic [AB-1:0] d0_reg;

    assign amp = s_axis_tdata[AB-1:0];

    always_comb
    begin
        a_calc_next = 1'b0;
        if (amp >= upper_reg)
        begin
            a_rgn_next = a2mv_pkg::REGION_ABOVE;
        end
        else if (amp <= lower_reg)
        begin
            a_rgn_next = a2mv_pkg::REGION_BELOW;
        end
        else
        begin
            a_rgn_next  = a2mv_pkg::REGION_BETWEEN;
            a_calc_next = (amp > floor_reg) && (lower_reg > floor_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_A])
        begin
            a_rgn_reg  <= a_rgn_next;
            a_calc_reg <= a_calc_next;
            d1_reg     <= amp - floor_reg;
            d0_reg     <= lower_reg - floor_reg;
        end
    end

    // stage b and fraction stages: index 0 is the normalized operand
    logic [MB-1:0]  m1_reg   [LFB+1];
    logic [MB-1:0]  m0_reg   [LFB+1];
    logic [EW-1:0]  e1_reg   [LFB+1];
    logic [EW-1:0]  e0_reg   [LFB+1];
    logic [LFB-1:0] f1_reg   [LFB+1];
    logic [LFB-1:0] f0_reg   [LFB+1];
    logic [RB-1:0]  rgn_reg  [LFB+1];
    logic           calc_reg [LFB+1];

    // stage b: leading one and normalize
    logic [EW-1:0] e1_next;
    logic [EW-1:0] e0_next;

    assign e1_next = lead_one(d1_reg);
    assign e0_next = lead_one(d0_reg);

    always_ff @(posedge clk)
    begin
        if (en[ST_B])
        begin
            e1_reg[0]   <= e1_next;
            e0_reg[0]   <= e0_next;
            m1_reg[0]   <= normalize(d1_reg, e1_next);
            m0_reg[0]   <= normalize(d0_reg, e0_next);
            f1_reg[0]   <= '0;
            f0_reg[0]   <= '0;
            rgn_reg[0]  <= a_rgn_reg;
            calc_reg[0] <= a_calc_reg;
        end
    end

    // one fraction bit per stage: square, test against 2, halve
    for (genvar j = 1; j <= LFB; j++)
    begin : g_frac
        logic [SQW-1:0] sq1;
        logic [SQW-1:0] sq0;
        logic [MB:0]    s1;
        logic [MB:0]    s0;

        assign sq1 = SQW'(m1_reg[j-1]) * SQW'(m1_reg[j-1]);
        assign sq0 = SQW'(m0_reg[j-1]) * SQW'(m0_reg[j-1]);
        assign s1  = sq1[SQW-1:a2mv_pkg::MANT_FRAC];
        assign s0  = sq0[SQW-1:a2mv_pkg::MANT_FRAC];

        always_ff @(posedge clk)
        begin
            if (en[ST_B + j])
            begin
                m1_reg[j]   <= s1[MB] ? s1[MB:1] : s1[MB-1:0];
                m0_reg[j]   <= s0[MB] ? s0[MB:1] : s0[MB-1:0];
                f1_reg[j]   <= {f1_reg[j-1][LFB-2:0], s1[MB]};
                f0_reg[j]   <= {f0_reg[j-1][LFB-2:0], s0[MB]};
                e1_reg[j]   <= e1_reg[j-1];
                e0_reg[j]   <= e0_reg[j-1];
                rgn_reg[j]  <= rgn_reg[j-1];
                calc_reg[j] <= calc_reg[j-1];
            end
        end
    end

    // stage d: log difference, clamped at zero, and zero unless the word is to be calculated
    logic [LW-1:0] l1;
    logic [LW-1:0] l0;
    logic [LW-1:0] diff_reg;
    logic [RB-1:0] d_rgn_reg;

    assign l1 = {e1_reg[LFB], f1_reg[LFB]};
    assign l0 = {e0_reg[LFB], f0_reg[LFB]};

    always_ff @(posedge clk)
    begin
        if (en[ST_D])
        begin
            diff_reg  <= (calc_reg[LFB] && (l1 > l0)) ? (l1 - l0) : '0;
            d_rgn_reg <= rgn_reg[LFB];
        end
    end

    // stage m1: octaves to decibels
    logic [P1W-1:0] p1_reg;
    logic [RB-1:0]  m1_rgn_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_M1])
        begin
            p1_reg     <= P1W'(diff_reg) * P1W'(a2mv_pkg::DB_PER_OCTAVE_Q16);
            m1_rgn_reg <= d_rgn_reg;
        end
    end

    // stage m2: decibels to velocity steps
    logic [P2W-1:0] p2_reg;
    logic [RB-1:0]  m2_rgn_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_M2])
        begin
            p2_reg     <= P2W'(p1_reg) * P2W'(vpd_reg);
            m2_rgn_reg <= m1_rgn_reg;
        end
    end

    // output stage: truncate, saturate and pick the region
    logic [HW-1:0] vhi;
    logic [VB-1:0] vel_next;
    logic [RB-1:0] rgn_next;
    logic [VB-1:0] vel_reg;
    logic [RB-1:0] o_rgn_reg;

    assign vhi = p2_reg[P2W-1:SH];

    always_comb
    begin
        vel_next = vhi[VB-1:0];
        rgn_next = m2_rgn_reg;
        unique case (m2_rgn_reg)
            a2mv_pkg::REGION_ABOVE:
            begin
                vel_next = VB'(a2mv_pkg::VELOCITY_MAX);
            end
            a2mv_pkg::REGION_BELOW:
            begin
                vel_next = '0;
            end
            default:
            begin
                if (|vhi[HW-1:VB])
                begin
                    vel_next = VB'(a2mv_pkg::VELOCITY_MAX);
                    rgn_next = a2mv_pkg::REGION_CLIPPED;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_O])
        begin
            vel_reg   <= vel_next;
            o_rgn_reg <= rgn_next;
        end
    end

    assign m_axis_tvalid = vld_reg[ST_O];
    assign m_axis_tdata  = {1'b0, vel_reg};
    assign m_axis_tuser  = o_rgn_reg;

endmodule
